// ===== rtl/timeout_table_defines.svh =====
// ============================================================================
// timeout_table_defines.svh
// Assertion macros shared by the timeout table RTL.
// ============================================================================
`ifndef TIMEOUT_TABLE_DEFINES_SVH
`define TIMEOUT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timeout_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define TT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timeout_table: next-cycle check failed");

`endif

// ===== rtl/tt_pkg.sv =====
// ============================================================================
// tt_pkg
// Types and codes for the timeout table: slot entry, head flags, op codes.
// ============================================================================
package tt_pkg;

    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;

    // Request actions
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_DELAY   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL      = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One slot of the table
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
    } t_entry;

    // Flags for the slot at the head of the ring
    typedef struct packed {
        logic expired;
        logic match;
        logic free;
    } t_flags;

endpackage

// ===== rtl/tt_cell.sv =====
// ============================================================================
// tt_cell
// One slot of the ring: holds an entry and takes its neighbor's on a shift.
// ============================================================================
module tt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  tt_pkg::t_entry i_entry,
    output tt_pkg::t_entry o_entry
);

    logic                        r_valid;
    logic [tt_pkg::HANDLE_W-1:0] r_handle;
    logic [tt_pkg::TIME_W-1:0]   r_deadline;

    // Valid bit is control state and clears on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    // Payload only moves with the ring
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_handle   <= i_entry.handle;
            r_deadline <= i_entry.deadline;
        end
    end

    assign o_entry.valid    = r_valid;
    assign o_entry.handle   = r_handle;
    assign o_entry.deadline = r_deadline;

endmodule

// ===== rtl/tt_eval.sv =====
// ============================================================================
// tt_eval
// Tests the head slot: expired against the clock, handle match, free.
// ============================================================================
module tt_eval (
    input  tt_pkg::t_entry              i_entry,
    input  logic [tt_pkg::TIME_W-1:0]   i_now,
    input  logic [tt_pkg::HANDLE_W-1:0] i_handle,
    output tt_pkg::t_flags              o_flags
);

    // Overdue means now strictly past the deadline, plain unsigned compare
    always_comb begin
        o_flags.expired = i_entry.valid && (i_now > i_entry.deadline);
        o_flags.match   = i_entry.valid && (i_entry.handle == i_handle);
        o_flags.free    = !i_entry.valid;
    end

endmodule

// ===== rtl/timeout_table.sv =====
// ============================================================================
// timeout_table
// Table of pending timeouts keyed by handle, stored in a ring of slot cells
// that rotates past one head evaluator.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------
//   in      | sink      | i_in_valid/o_in_ready: action, handle, timeout
//   out     | source    | o_out_valid/i_out_ready: kind, handle, delay,
//           |           |   status, last
//   cfg     | sink      | i_cfg_valid/o_cfg_ready: default timeout
//
// Remove, tick and query rotate the ring once before the closing result;
// add rotates twice (search, then write). A null-handle add or remove goes
// straight to its result without a rotation. A new request is taken only
// in idle, once the closing result of the last one is in the output
// register. Every slot passes the single head evaluator in turn. An
// expired entry waiting on a full output register stalls the ring; the
// closing result waits for a free output register. Reset empties the table
// and zeroes the clock.
// ============================================================================
module timeout_table #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_handle,
    input  logic [31:0] i_timeout_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_handle_out,
    output logic [15:0] o_delay_ms,
    output logic [1:0]  o_status,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_default_timeout
);

    `include "timeout_table_defines.svh"

    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW_EFF = (HANDLE_BITS < tt_pkg::HANDLE_W) ? HANDLE_BITS
                                                               : tt_pkg::HANDLE_W;
    localparam logic [tt_pkg::HANDLE_W-1:0] HMASK =
        tt_pkg::HANDLE_W'((17'd1 << HW_EFF) - 17'd1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [1:0]                  r_op;
    logic [tt_pkg::HANDLE_W-1:0] r_h;
    logic [tt_pkg::TIME_W-1:0]   r_tmo;
    logic [tt_pkg::TIME_W-1:0]   r_now;
    logic [IW-1:0]               r_cnt;
    logic                        r_null;
    logic                        r_found;
    logic [IW-1:0]               r_tidx;
    logic                        r_free_ok;
    logic [IW-1:0]               r_fidx;
    logic                        r_any;
    logic [tt_pkg::TIME_W-1:0]   r_best;
    logic [15:0]                 r_dt;

    logic                        r_o_valid;
    logic [1:0]                  r_o_kind;
    logic [15:0]                 r_o_handle;
    logic [15:0]                 r_o_delay;
    logic [1:0]                  r_o_status;
    logic                        r_o_last;

    tt_pkg::t_entry              ring [SLOTS];
    tt_pkg::t_entry              head, new_head;
    tt_pkg::t_flags              flags;

    logic                        in_acc;
    logic                        out_free;
    logic                        exp_hit;
    logic                        ring_shift;
    logic                        at_end;
    logic                        do_write;
    logic [IW-1:0]               target;
    logic [tt_pkg::HANDLE_W-1:0] h_masked;
    logic [tt_pkg::TIME_W-1:0]   gap;
    logic                        use_gap;
    logic [15:0]                 q_delay;
    logic [1:0]                  fin_status;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign head     = ring[0];
    assign h_masked = i_handle & HMASK;
    assign at_end   = (r_cnt == LAST_IDX);
    assign target   = r_found ? r_tidx : r_fidx;

    // Head slot evaluation
    tt_eval u_eval (
        .i_entry  (head),
        .i_now    (r_now),
        .i_handle (r_h),
        .o_flags  (flags)
    );

    // Expiry only applies to tick and query scans
    assign exp_hit  = (r_state == S_SCAN) && flags.expired &&
                      ((r_op == tt_pkg::ACT_TICK) || (r_op == tt_pkg::ACT_QUERY));
    assign do_write = (r_state == S_WRITE) && (r_cnt == target) &&
                      (r_found || r_free_ok);
    assign ring_shift = ((r_state == S_SCAN) && (!exp_hit || out_free)) ||
                        (r_state == S_WRITE);

    // Updated head entry going back in at the tail
    always_comb begin
        new_head = head;
        if (exp_hit) begin
            new_head.valid = 1'b0;
        end else if ((r_state == S_SCAN) && (r_op == tt_pkg::ACT_REMOVE) && flags.match) begin
            new_head.valid = 1'b0;
        end else if (do_write) begin
            new_head.valid    = 1'b1;
            new_head.handle   = r_h;
            new_head.deadline = r_now + r_tmo;
        end
    end

    // Ring of slot cells, each loading its upper neighbor
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        tt_pkg::t_entry cell_in;
        if (k == SLOTS - 1) begin : g_tail
            assign cell_in = new_head;
        end else begin : g_mid
            assign cell_in = ring[k+1];
        end
        tt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (ring_shift),
            .i_entry (cell_in),
            .o_entry (ring[k])
        );
    end

    // Next delay and final status
    always_comb begin
        gap     = r_best - r_now;
        use_gap = r_any && (gap != '0) && (gap <= {16'd0, r_dt});
        q_delay = use_gap ? gap[15:0] : r_dt;
        if (r_null) begin
            fin_status = tt_pkg::ST_NULL;
        end else if (r_op == tt_pkg::ACT_ADD) begin
            fin_status = (r_found || r_free_ok) ? tt_pkg::ST_OK : tt_pkg::ST_FULL;
        end else if (r_op == tt_pkg::ACT_REMOVE) begin
            fin_status = r_found ? tt_pkg::ST_OK : tt_pkg::ST_NOT_FOUND;
        end else begin
            fin_status = tt_pkg::ST_OK;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (((i_action == tt_pkg::ACT_ADD) || (i_action == tt_pkg::ACT_REMOVE)) &&
                        (h_masked == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ring_shift && at_end) begin
                    n_state = (r_op == tt_pkg::ACT_ADD) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                if (at_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_cnt   <= '0;
            r_dt    <= 16'd1000;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dt <= i_cfg_default_timeout;
            end
            if (in_acc && (i_action == tt_pkg::ACT_TICK)) begin
                r_now <= r_now + 32'd1;
            end
            if (in_acc) begin
                r_cnt <= '0;
            end else if (ring_shift) begin
                r_cnt <= at_end ? '0 : r_cnt + IW'(1);
            end
        end
    end

    // Request latch and scan tracking
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= i_action;
            r_h       <= h_masked;
            r_tmo     <= i_timeout_ms;
            r_null    <= ((i_action == tt_pkg::ACT_ADD) || (i_action == tt_pkg::ACT_REMOVE)) &&
                         (h_masked == '0);
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_any     <= 1'b0;
        end else if ((r_state == S_SCAN) && ring_shift) begin
            if ((r_op == tt_pkg::ACT_ADD) || (r_op == tt_pkg::ACT_REMOVE)) begin
                if (flags.match) begin
                    r_found <= 1'b1;
                    r_tidx  <= r_cnt;
                end
                if (flags.free && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_fidx    <= r_cnt;
                end
            end else if (!exp_hit && head.valid && (r_op == tt_pkg::ACT_QUERY)) begin
                if (!r_any || (head.deadline < r_best)) begin
                    r_any  <= 1'b1;
                    r_best <= head.deadline;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (exp_hit && out_free) begin
            r_o_valid <= 1'b1;
        end else if ((r_state == S_DONE) && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exp_hit && out_free) begin
            r_o_kind   <= tt_pkg::KIND_EXPIRED;
            r_o_handle <= head.handle;
            r_o_delay  <= '0;
            r_o_status <= tt_pkg::ST_OK;
            r_o_last   <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_o_kind   <= (r_op == tt_pkg::ACT_QUERY && !r_null) ? tt_pkg::KIND_DELAY
                                                                 : tt_pkg::KIND_STATUS;
            r_o_handle <= '0;
            r_o_delay  <= (r_op == tt_pkg::ACT_QUERY && !r_null) ? q_delay : 16'd0;
            r_o_status <= fin_status;
            r_o_last   <= 1'b1;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_handle_out = r_o_handle;
    assign o_delay_ms   = r_o_delay;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

    // Returning to idle leaves the closing result in the output register
    `TT_ASSERT_IMP(a_done_last, ($past(r_state) != S_IDLE) && (r_state == S_IDLE), r_o_valid && r_o_last)
    // A tick request advances the clock by exactly one
    `TT_ASSERT_NXT(a_tick_step, in_acc && (i_action == tt_pkg::ACT_TICK), r_now == $past(r_now) + 32'd1)
    // A stalled scan holds its slot position
    `TT_ASSERT_NXT(a_stall_hold, (r_state == S_SCAN) && !ring_shift, $stable(r_cnt))

endmodule

// ===== tb/timeout_table_checker.sv =====
// ============================================================================
// timeout_table_checker
// Watches the request, result and configuration channels of the timeout
// table. It keeps its own copy of the table, the millisecond counter and the
// default timeout, predicts the results of each accepted request, and
// compares every accepted result field by field with the oldest prediction.
// ============================================================================
module timeout_table_checker #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_handle,
    input  logic [31:0] i_timeout_ms,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_handle_out,
    input  logic [15:0] i_delay_ms,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    // configuration channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_default_timeout,
    // to the testbench top
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle_out;
        logic [15:0] delay_ms;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Shadow of the table
    logic        slot_used     [SLOTS];
    logic [15:0] slot_handle   [SLOTS];
    logic [31:0] slot_deadline [SLOTS];
    logic [31:0] clock_ms;
    logic [15:0] dflt_timeout;

    t_result     pending_results[$];
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic t_result make_result(input logic [1:0] kind,
                                            input logic [15:0] h,
                                            input logic [15:0] delay,
                                            input logic [1:0] st);
        t_result r;
        r.kind       = kind;
        r.handle_out = h;
        r.delay_ms   = delay;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic int find_slot(input logic [15:0] h);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_handle[i] == h) return i;
        end
        return -1;
    endfunction

    // Drop every entry whose deadline has passed, in slot order
    task automatic expire_overdue();
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && clock_ms > slot_deadline[i]) begin
                pending_results.push_back(make_result(tt_pkg::KIND_EXPIRED, slot_handle[i],
                                                      16'd0, tt_pkg::ST_OK));
                slot_used[i] = 1'b0;
            end
        end
    endtask

    // Update the shadow table and queue the results of one request
    task automatic predict_request(input logic [1:0] act, input logic [15:0] h,
                                   input logic [31:0] tmo);
        int          slot;
        logic [1:0]  st;
        logic        any;
        logic [31:0] best;
        logic [31:0] gap;
        logic [15:0] delay;
        t_result     tail;
        st   = tt_pkg::ST_OK;
        any  = 1'b0;
        best = '0;
        case (act)
            tt_pkg::ACT_ADD: begin
                if (h == 16'd0) begin
                    st = tt_pkg::ST_NULL;
                end else begin
                    slot = find_slot(h);
                    // new handles take the lowest free slot
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot < 0 && !slot_used[i]) slot = i;
                    end
                    if (slot < 0) begin
                        st = tt_pkg::ST_FULL;
                    end else begin
                        slot_used[slot]     = 1'b1;
                        slot_handle[slot]   = h;
                        slot_deadline[slot] = clock_ms + tmo;
                    end
                end
                pending_results.push_back(make_result(tt_pkg::KIND_STATUS, 16'd0, 16'd0, st));
            end
            tt_pkg::ACT_REMOVE: begin
                if (h == 16'd0) begin
                    st = tt_pkg::ST_NULL;
                end else begin
                    slot = find_slot(h);
                    if (slot < 0) st = tt_pkg::ST_NOT_FOUND;
                    else slot_used[slot] = 1'b0;
                end
                pending_results.push_back(make_result(tt_pkg::KIND_STATUS, 16'd0, 16'd0, st));
            end
            tt_pkg::ACT_TICK: begin
                clock_ms = clock_ms + 32'd1;
                expire_overdue();
                pending_results.push_back(make_result(tt_pkg::KIND_STATUS, 16'd0, 16'd0,
                                                      tt_pkg::ST_OK));
            end
            default: begin
                expire_overdue();
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && (!any || slot_deadline[i] < best)) begin
                        best = slot_deadline[i];
                        any  = 1'b1;
                    end
                end
                // zero gap or a gap beyond the default reports the default
                delay = dflt_timeout;
                if (any) begin
                    gap = best - clock_ms;
                    if (gap != 32'd0 && gap <= {16'd0, dflt_timeout}) delay = gap[15:0];
                end
                pending_results.push_back(make_result(tt_pkg::KIND_DELAY, 16'd0, delay,
                                                      tt_pkg::ST_OK));
            end
        endcase
        tail      = pending_results.pop_back();
        tail.last = 1'b1;
        pending_results.push_back(tail);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Track configuration, predict on requests, compare on results
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
            clock_ms     = '0;
            dflt_timeout = 16'd1000;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) dflt_timeout = i_cfg_default_timeout;
            if (i_in_valid && i_in_ready) predict_request(i_action, i_handle, i_timeout_ms);
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: kind 0x%0h handle 0x%0h",
                           i_kind, i_handle_out);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind",       32'(want.kind),       32'(i_kind));
                    check_field("handle_out", 32'(want.handle_out), 32'(i_handle_out));
                    check_field("delay_ms",   32'(want.delay_ms),   32'(i_delay_ms));
                    check_field("status",     32'(want.status),     32'(i_status));
                    check_field("last",       32'(want.last),       32'(i_last));
                end
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// ===== tb/timeout_table_tb.sv =====
// ============================================================================
// timeout_table_tb
// Drives the timeout table with a directed sequence (null handles, missing
// handles, overwrite, full table, wrapped deadlines, zero gap), then random
// requests under several default timeouts, with random gaps on both channels
// in all but one phase. The checker by the block predicts and checks results.
// ============================================================================
module timeout_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    logic        i_clk                 = 1'b0;
    logic        i_rst_n               = 1'b0;
    logic        i_in_valid            = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action              = tt_pkg::ACT_ADD;
    logic [15:0] i_handle              = '0;
    logic [31:0] i_timeout_ms          = '0;
    logic        o_out_valid;
    logic        i_out_ready           = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_handle_out;
    logic [15:0] o_delay_ms;
    logic [1:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid           = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_default_timeout = 16'd1000;

    int   fail_count;
    int   pending_count;
    int   quiet_cycles = 0;
    logic gaps_on      = 1'b1;

    timeout_table #(.SLOTS(SLOTS), .HANDLE_BITS(16)) DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_action              (i_action),
        .i_handle              (i_handle),
        .i_timeout_ms          (i_timeout_ms),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_kind                (o_kind),
        .o_handle_out          (o_handle_out),
        .o_delay_ms            (o_delay_ms),
        .o_status              (o_status),
        .o_last                (o_last),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_default_timeout (i_cfg_default_timeout)
    );

    timeout_table_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_ready            (o_in_ready),
        .i_action              (i_action),
        .i_handle              (i_handle),
        .i_timeout_ms          (i_timeout_ms),
        .i_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .i_kind                (o_kind),
        .i_handle_out          (o_handle_out),
        .i_delay_ms            (o_delay_ms),
        .i_status              (o_status),
        .i_last                (o_last),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_default_timeout (i_cfg_default_timeout),
        .o_fail_count          (fail_count),
        .o_pending             (pending_count)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result-side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(99) >= 31);
    end

    // Watchdog: too long without any accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] act, input logic [15:0] h,
                                input logic [31:0] tmo);
        while (gaps_on && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_handle     <= h;
        i_timeout_ms <= tmo;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Hold off new requests until every predicted result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_default_timeout(input logic [15:0] value);
        wait_for_results();
        i_cfg_valid           <= 1'b1;
        i_cfg_default_timeout <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a small handle pool so adds, removes and full-table hits collide
    task automatic random_request();
        int          pick;
        logic [1:0]  act;
        logic [15:0] h;
        logic [31:0] tmo;
        pick = $urandom_range(99);
        if (pick < 38)      act = tt_pkg::ACT_ADD;
        else if (pick < 56) act = tt_pkg::ACT_REMOVE;
        else if (pick < 84) act = tt_pkg::ACT_TICK;
        else                act = tt_pkg::ACT_QUERY;
        pick = $urandom_range(99);
        if (pick < 80)      h = 16'($urandom_range(20, 1));
        else if (pick < 85) h = 16'd0;
        else                h = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 75)      tmo = $urandom_range(12);
        else if (pick < 88) tmo = $urandom_range(70000, 100);
        else                tmo = $urandom;
        send_request(act, h, tmo);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, null and missing handles
        send_request(tt_pkg::ACT_QUERY,  16'h0000, 32'd0);
        send_request(tt_pkg::ACT_ADD,    16'h0000, 32'd7);
        send_request(tt_pkg::ACT_REMOVE, 16'h0000, 32'd0);
        send_request(tt_pkg::ACT_REMOVE, 16'h1234, 32'd0);
        send_request(tt_pkg::ACT_TICK,   16'h0000, 32'd0);
        // wrapped deadline, zero timeout, then zero-gap query
        send_request(tt_pkg::ACT_ADD,    16'hFFFF, 32'hFFFF_FFFF);
        send_request(tt_pkg::ACT_ADD,    16'h0001, 32'd0);
        send_request(tt_pkg::ACT_ADD,    16'h5555, 32'd5);
        send_request(tt_pkg::ACT_QUERY,  16'h0000, 32'd0);
        // overwrite an existing deadline
        send_request(tt_pkg::ACT_ADD,    16'h5555, 32'd3);
        send_request(tt_pkg::ACT_TICK,   16'hAAAA, 32'd0);
        send_request(tt_pkg::ACT_QUERY,  16'h0000, 32'd0);
        // fill the table, hit it full, overwrite while full
        for (int i = 1; i <= SLOTS - 1; i++) begin
            send_request(tt_pkg::ACT_ADD, 16'(i), 32'd20 + 32'(i));
        end
        send_request(tt_pkg::ACT_ADD,    16'h0010, 32'd5);
        send_request(tt_pkg::ACT_ADD,    16'h0003, 32'hFFFF_FFFF);
        send_request(tt_pkg::ACT_TICK,   16'h0000, 32'd0);
        send_request(tt_pkg::ACT_QUERY,  16'h0000, 32'd0);

        // Random: largest default timeout
        write_default_timeout(16'hFFFF);
        for (int i = 0; i < 25; i++) random_request();

        // Random: smallest default timeout, no gaps on either side
        write_default_timeout(16'd1);
        gaps_on = 1'b0;
        for (int i = 0; i < 20; i++) random_request();

        // Random: mid-range default, with one full drain in the middle
        write_default_timeout(16'($urandom_range(999, 2)));
        gaps_on = 1'b1;
        for (int i = 0; i < 25; i++) begin
            if (i == 12) wait_for_results();
            random_request();
        end

        wait_for_results();
        gaps_on = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
